// ----- rtl/quadratic_probe_hash_table_defines.svh -----
// Assertion macros for the quadratic probe hash table.
// Used by the top level; depends on nothing else.
`ifndef QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define QPHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QPHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qpht_pkg.sv -----
// Shared types, constants and microcode encodings of the quadratic probe hash table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

  // Table geometry (table size must be a power of two)
  localparam int TABLE_SIZE  = 16;
  localparam int PROBE_LIMIT = 14;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W       = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_W       = 31;
  localparam int IDX_W       = 4;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OUT_INSERTED  = 3'd0,
    OUT_DUPLICATE = 3'd1,
    OUT_OVERFLOW  = 3'd2,
    OUT_FOUND     = 3'd3,
    OUT_NOT_FOUND = 3'd4,
    OUT_DELETED   = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_DELETED  = 2'd1,
    MARK_OCCUPIED = 2'd2
  } mark_e;

  // Request and response transactions
  typedef struct packed {
    kind_e              kind;
    logic [KEY_W-1:0]   key;
  } qpht_req_t;

  typedef struct packed {
    outcome_e           outcome;
    logic [IDX_W-1:0]   slot_index;
  } qpht_rsp_t;

  // Datapath actions selected by the control word
  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_PROBE   = 2'd1,
    ACT_FINISH  = 2'd2,
    ACT_EXHAUST = 2'd3
  } act_e;

  // Control from the sequencer to the datapath
  typedef struct packed {
    act_e act;
    logic idle;
  } qpht_ctrl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic done;
    logic last;
  } qpht_stat_t;

endpackage

`default_nettype wire

// ----- rtl/qpht_seq.sv -----
// Microcoded sequencer: step counter, control store and branch logic.
// Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpht_seq
  import qpht_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  qpht_stat_t stat_i,
  output qpht_ctrl_t ctrl_o
);

  localparam int STEP_W = 2;

  // Step addresses of the control store
  localparam logic [STEP_W-1:0] STEP_IDLE    = 2'd0;
  localparam logic [STEP_W-1:0] STEP_PROBE   = 2'd1;
  localparam logic [STEP_W-1:0] STEP_FINISH  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_EXHAUST = 2'd3;

  typedef enum logic [2:0] {
    COND_NEVER  = 3'd0,
    COND_START  = 3'd1,
    COND_DONE   = 3'd2,
    COND_LAST   = 3'd3,
    COND_ALWAYS = 3'd4
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond_a;
    logic [STEP_W-1:0] tgt_a;
    cond_e             cond_b;
    logic [STEP_W-1:0] tgt_b;
    logic [STEP_W-1:0] nxt;
  } ucode_t;

  // Control store: first taken branch wins, else fall to nxt
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    case (addr)
      STEP_IDLE:    w = '{ACT_IDLE, COND_START, STEP_PROBE, COND_NEVER, STEP_IDLE, STEP_IDLE};
      STEP_PROBE:   w = '{ACT_PROBE, COND_DONE, STEP_FINISH, COND_LAST, STEP_EXHAUST,
                          STEP_PROBE};
      STEP_FINISH:  w = '{ACT_FINISH, COND_ALWAYS, STEP_IDLE, COND_NEVER, STEP_IDLE,
                          STEP_IDLE};
      STEP_EXHAUST: w = '{ACT_EXHAUST, COND_ALWAYS, STEP_IDLE, COND_NEVER, STEP_IDLE,
                          STEP_IDLE};
      default:      w = '{ACT_IDLE, COND_NEVER, STEP_IDLE, COND_NEVER, STEP_IDLE, STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic cond_true(input cond_e c, input logic start,
                                     input qpht_stat_t st);
    logic r;
    case (c)
      COND_START:  r = start;
      COND_DONE:   r = st.done;
      COND_LAST:   r = st.last;
      COND_ALWAYS: r = 1'b1;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uword;

  // Fetch the control word and resolve the branch
  always_comb begin
    uword = ucode_rom(step_q);
    if (cond_true(uword.cond_a, start_i, stat_i)) begin
      step_d = uword.tgt_a;
    end else if (cond_true(uword.cond_b, start_i, stat_i)) begin
      step_d = uword.tgt_b;
    end else begin
      step_d = uword.nxt;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.act  = uword.act;
  assign ctrl_o.idle = (step_q == STEP_IDLE);

endmodule

`default_nettype wire

// ----- rtl/qpht_dpath.sv -----
// Datapath: probe registers, key memory, slot marks and response register.
// Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpht_dpath
  import qpht_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  qpht_req_t  req_i,
  input  qpht_ctrl_t ctrl_i,
  output qpht_stat_t stat_o,
  output logic       done_o,
  output qpht_rsp_t  rsp_o
);

  // Request and probe walk registers
  kind_e              kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [SLOT_W-1:0]  inc_q;
  logic [CNT_W-1:0]   cnt_q;

  // Slot storage
  logic [KEY_W-1:0]   key_mem [TABLE_SIZE];
  logic [KEY_W-1:0]   rd_key_q;
  mark_e              mark_q  [TABLE_SIZE];

  logic               done_q;
  qpht_rsp_t          rsp_q;

  logic               load;
  logic               advance;
  logic [SLOT_W-1:0]  rd_addr;
  mark_e              mark_cur;
  logic               match;
  logic               hit_done;
  outcome_e           hit_outcome;
  logic [IDX_W-1:0]   hit_slot;
  logic               wr_key;
  logic               wr_del;

  // Classify the current probe
  always_comb begin
    mark_cur    = mark_q[slot_q];
    match       = (mark_cur == MARK_OCCUPIED) && (rd_key_q == key_q);
    hit_done    = 1'b0;
    hit_outcome = OUT_NOT_FOUND;
    hit_slot    = '0;
    case (kind_q)
      KIND_INSERT: begin
        if (mark_cur != MARK_OCCUPIED) begin
          hit_done    = 1'b1;
          hit_outcome = OUT_INSERTED;
          hit_slot    = IDX_W'(slot_q);
        end else if (match) begin
          hit_done    = 1'b1;
          hit_outcome = OUT_DUPLICATE;
          hit_slot    = IDX_W'(slot_q);
        end
      end
      KIND_SEARCH, KIND_DELETE: begin
        if (mark_cur == MARK_EMPTY) begin
          hit_done = 1'b1;
        end else if (match) begin
          hit_done    = 1'b1;
          hit_outcome = (kind_q == KIND_SEARCH) ? OUT_FOUND : OUT_DELETED;
          hit_slot    = IDX_W'(slot_q);
        end
      end
      default: begin
        hit_done = 1'b1;
      end
    endcase
  end

  assign stat_o.done = hit_done;
  assign stat_o.last = (cnt_q == CNT_W'(PROBE_LIMIT - 1));

  assign load    = (ctrl_i.act == ACT_IDLE) && start_i;
  assign advance = (ctrl_i.act == ACT_PROBE) && !hit_done;
  assign wr_key  = (ctrl_i.act == ACT_FINISH) && (hit_outcome == OUT_INSERTED);
  assign wr_del  = (ctrl_i.act == ACT_FINISH) && (hit_outcome == OUT_DELETED);

  // Read the home slot on load, the next probe slot on advance
  always_comb begin
    if (load) begin
      rd_addr = req_i.key[SLOT_W-1:0];
    end else if (advance) begin
      rd_addr = slot_q + inc_q;
    end else begin
      rd_addr = slot_q;
    end
  end

  // Hold the request and step the quadratic walk by odd increments
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= req_i.kind;
      key_q  <= req_i.key;
      slot_q <= req_i.key[SLOT_W-1:0];
      inc_q  <= SLOT_W'(1);
      cnt_q  <= '0;
    end else if (advance) begin
      slot_q <= slot_q + inc_q;
      inc_q  <= inc_q + SLOT_W'(2);
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  // Key memory with registered read
  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_mem[slot_q] <= key_q;
    end
    rd_key_q <= key_mem[rd_addr];
  end

  // Slot marks, cleared to empty at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        mark_q[i] <= MARK_EMPTY;
      end
    end else if (wr_key) begin
      mark_q[slot_q] <= MARK_OCCUPIED;
    end else if (wr_del) begin
      mark_q[slot_q] <= MARK_DELETED;
    end
  end

  // Response strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (ctrl_i.act == ACT_FINISH) || (ctrl_i.act == ACT_EXHAUST);
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.act == ACT_FINISH) begin
      rsp_q.outcome    <= hit_outcome;
      rsp_q.slot_index <= hit_slot;
    end else if (ctrl_i.act == ACT_EXHAUST) begin
      rsp_q.outcome    <= (kind_q == KIND_INSERT) ? OUT_OVERFLOW : OUT_NOT_FOUND;
      rsp_q.slot_index <= '0;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/quadratic_probe_hash_table.sv -----
// Top level of the quadratic probe hash table: sequencer, datapath and checks.
// Depends on qpht_pkg, qpht_seq, qpht_dpath and the assertion macro header.
//
// Usage:
//   A request transaction (insert, search or delete of one key) is taken at
//   a clock edge where start is high and busy is low. busy stays high until
//   the response is issued.
//   The response is driven on rsp_o for exactly one cycle with done_o high;
//   the receiver must take it in that cycle and cannot stall it.
//   Probing: a request stops on probe k (k = 1 .. 14) or runs out of probes
//   after probe 14. The probe step of the sequencer visits one slot per
//   cycle through the single read port of the key memory; a finish or
//   exhaust step then commits any write and registers the response.
//   busy falls in the cycle that done_o is high, so the next request may
//   be taken at the edge that ends the response cycle.
//   Reset marks every slot empty at once; no clearing pass is needed and
//   the block accepts a request in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_probe_hash_table_defines.svh"

module quadratic_probe_hash_table
  import qpht_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start,
  output logic      busy,
  input  qpht_req_t req_i,
  output logic      done_o,
  output qpht_rsp_t rsp_o
);

  qpht_ctrl_t ctrl;
  qpht_stat_t stat;

  qpht_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  qpht_dpath u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

  assign busy = !ctrl.idle;

  // Checks
  `QPHT_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy, "response while busy")
  `QPHT_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept did not start")
  `QPHT_ASSERT_NXT(a_single_rsp, clk_i, rst_ni, done_o, !done_o, "response repeated")
  `QPHT_ASSERT_IMP(a_miss_slot, clk_i, rst_ni,
    done_o && (rsp_o.outcome == OUT_OVERFLOW || rsp_o.outcome == OUT_NOT_FOUND),
    rsp_o.slot_index == '0, "miss carries a slot")

endmodule

`default_nettype wire

// ----- bench/quadratic_probe_hash_table_test.sv -----
// Self-checking testbench for the quadratic probe hash table.
// Depends on qpht_pkg and the quadratic_probe_hash_table top level; it keeps a shadow
// copy of the slot table, predicts every response and compares it field by field.
`timescale 1ns / 1ps

module quadratic_probe_hash_table_test;
  import qpht_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int POOL_DEPTH  = 48;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  logic      busy;
  qpht_req_t req_i;
  logic      done_o;
  qpht_rsp_t rsp_o;

  // Shadow copy of the table contents
  logic [KEY_W-1:0] shadow_keys [TABLE_SIZE];
  mark_e            shadow_marks[TABLE_SIZE];

  qpht_rsp_t        pending_rsp[$];
  logic [KEY_W-1:0] key_pool[$];
  qpht_rsp_t        want;
  int               err_count = 0;
  int               accepted = 0;
  int               stall_cycles = 0;
  int               outcome_seen[6];
  bit               no_idle = 1'b0;

  quadratic_probe_hash_table u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
    err_count++;
  endtask

  // Apply one request to the shadow table and return the response it must produce
  function automatic qpht_rsp_t apply_request(input qpht_req_t r);
    qpht_rsp_t   rsp;
    int unsigned home;
    int unsigned s;
    int unsigned hit;
    bit          stop;
    rsp.outcome    = OUT_NOT_FOUND;
    rsp.slot_index = '0;
    home = r.key % TABLE_SIZE;
    stop = 1'b0;
    hit  = TABLE_SIZE;
    case (r.kind)
      KIND_INSERT: begin
        rsp.outcome = OUT_OVERFLOW;
        for (int j = 0; j < PROBE_LIMIT && !stop; j++) begin
          s = (home + j * j) % TABLE_SIZE;
          if (shadow_marks[s] != MARK_OCCUPIED) begin
            shadow_keys[s]  = r.key;
            shadow_marks[s] = MARK_OCCUPIED;
            rsp.outcome     = OUT_INSERTED;
            rsp.slot_index  = IDX_W'(s);
            stop = 1'b1;
          end else if (shadow_keys[s] == r.key) begin
            rsp.outcome    = OUT_DUPLICATE;
            rsp.slot_index = IDX_W'(s);
            stop = 1'b1;
          end
        end
      end
      KIND_SEARCH, KIND_DELETE: begin
        // Walk until an empty slot; deleted slots are passed over
        for (int j = 0; j < PROBE_LIMIT && !stop; j++) begin
          s = (home + j * j) % TABLE_SIZE;
          if (shadow_marks[s] == MARK_EMPTY) begin
            stop = 1'b1;
          end else if (shadow_marks[s] == MARK_OCCUPIED && shadow_keys[s] == r.key) begin
            hit  = s;
            stop = 1'b1;
          end
        end
        if (hit < TABLE_SIZE) begin
          if (r.kind == KIND_SEARCH) begin
            rsp.outcome = OUT_FOUND;
          end else begin
            shadow_marks[hit] = MARK_DELETED;
            rsp.outcome       = OUT_DELETED;
          end
          rsp.slot_index = IDX_W'(hit);
        end
      end
      default: begin
        // Unused kind leaves the table alone
      end
    endcase
    return rsp;
  endfunction

  // Check responses, record accepted requests, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("response with nothing pending, outcome", rsp_o.outcome, 0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp_o.outcome !== want.outcome)
            report_mismatch("outcome", rsp_o.outcome, want.outcome);
          if (rsp_o.slot_index !== want.slot_index)
            report_mismatch("slot_index", rsp_o.slot_index, want.slot_index);
          if (want.outcome <= OUT_DELETED) outcome_seen[want.outcome]++;
        end
      end
      if (start && !busy) begin
        pending_rsp.push_back(apply_request(req_i));
        accepted++;
      end
      if (done_o || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d responses pending", pending_rsp.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Hold one request until the block takes it, then idle in a short burst now and then
  task automatic send_req(input kind_e kind, input logic [KEY_W-1:0] key);
    qpht_req_t r;
    r.kind = kind;
    r.key  = key;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Random key, often crowded onto a few home slots
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom);
    if ($urandom_range(0, 1) == 0) k[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 3));
    if ($urandom_range(0, 40) == 0) k = '0;
    if ($urandom_range(0, 40) == 0) k = '1;
    return k;
  endfunction

  // Lookups, deletes and the unused kind on a table that has never been written
  task automatic test_empty_table();
    send_req(KIND_SEARCH, '0);
    send_req(KIND_DELETE, '1);
    send_req(kind_e'(2'd3), 31'h2AAA_5555);
  endtask

  // Extreme keys, a duplicate, and the unused kind on a stored key
  task automatic test_insert_extremes();
    send_req(KIND_INSERT, '0);
    send_req(KIND_INSERT, '1);
    send_req(KIND_INSERT, '0);
    send_req(KIND_SEARCH, '0);
    send_req(KIND_SEARCH, '1);
    send_req(kind_e'(2'd3), '1);
  endtask

  // Fill all four slots that home 5 can reach, overflow it, then insert a stored key again
  task automatic test_probe_overflow();
    send_req(KIND_INSERT, 31'd5);
    send_req(KIND_INSERT, 31'd21);
    send_req(KIND_INSERT, 31'd37);
    send_req(KIND_INSERT, 31'd53);
    send_req(KIND_INSERT, 31'd69);
    send_req(KIND_INSERT, 31'd53);
  endtask

  // Search past a deleted slot, delete twice, reuse the deleted slot
  task automatic test_deleted_slots();
    send_req(KIND_DELETE, 31'd21);
    send_req(KIND_SEARCH, 31'd37);
    send_req(KIND_DELETE, 31'd21);
    send_req(KIND_INSERT, 31'd69);
    send_req(KIND_SEARCH, 31'd21);
    send_req(KIND_DELETE, 31'd7);
  endtask

  // Mixed traffic; searches and deletes mostly reuse keys already seen so hits and deletes happen
  task automatic test_random_traffic(input int count);
    int               pick;
    kind_e            op;
    logic [KEY_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = KIND_INSERT;
      else if (pick < 65) op = KIND_SEARCH;
      else if (pick < 95) op = KIND_DELETE;
      else op = kind_e'(2'd3);
      if (key_pool.size() > 0 &&
          ((op != KIND_INSERT && $urandom_range(0, 2) != 0) ||
           (op == KIND_INSERT && $urandom_range(0, 4) == 0)))
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else
        k = fresh_key();
      if (op == KIND_INSERT) begin
        key_pool.push_back(k);
        if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
      send_req(op, k);
    end
  endtask

  // Stop sending until every response is back
  task automatic test_drain_pause();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Back-to-back requests with no idle cycles
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_random_traffic(count);
  endtask

  initial begin
    int waited;
    for (int i = 0; i < TABLE_SIZE; i++) shadow_marks[i] = MARK_EMPTY;
    for (int i = 0; i < 6; i++) outcome_seen[i] = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_insert_extremes();
    test_probe_overflow();
    test_deleted_slots();
    test_random_traffic(400);
    test_drain_pause();
    test_random_traffic(300);
    test_back_to_back(150);

    // Drain the remaining responses, then watch for strays
    start <= 1'b0;
    waited = 0;
    while (pending_rsp.size() != 0 && waited < STALL_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_rsp.size() != 0)
      report_mismatch("responses never arrived, count", pending_rsp.size(), 0);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests of every kind with idle bursts and a drain pause.",
             accepted);
    $display("Outcomes: %0d inserted, %0d duplicate, %0d overflow, %0d found, %0d not found, %0d deleted",
             outcome_seen[OUT_INSERTED], outcome_seen[OUT_DUPLICATE],
             outcome_seen[OUT_OVERFLOW], outcome_seen[OUT_FOUND],
             outcome_seen[OUT_NOT_FOUND], outcome_seen[OUT_DELETED]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qpht_pkg.sv
rtl/qpht_seq.sv
rtl/qpht_dpath.sv
rtl/quadratic_probe_hash_table.sv
bench/quadratic_probe_hash_table_test.sv
